@@ design/ebr_pkg.sv @@
`default_nettype none
package ebr_pkg;

    localparam int DATA_W = 64;
    localparam int ALU_W = DATA_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED = 1'b1;

    typedef enum logic [2:0] {
        MODE_LATEST = 3'd0,
        MODE_AVG    = 3'd1,
        MODE_MAX    = 3'd2,
        MODE_MIN    = 3'd3,
        MODE_SUM    = 3'd4
    } t_agg_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EPOCH,
        S_MERGE,
        S_MERGE_META,
        S_TAIL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] slot_value;
        logic [DATA_W-1:0] slot_meta;
        logic [DATA_W-1:0] slot_epoch;
        logic              last;
    } t_ebr_in;

    typedef struct packed {
        logic [DATA_W-1:0] reduced_value;
        logic [DATA_W-1:0] newest_epoch;
        logic              div_zero;
    } t_ebr_out;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

endpackage
`default_nettype wire

@@ design/ebr_alu.sv @@
`default_nettype none
module ebr_alu (
    input  wire ebr_pkg::t_alu_req i_req,
    output ebr_pkg::t_alu_rsp      o_rsp
);
    import ebr_pkg::*;

    logic [ALU_W:0] w_full;

    // Subtraction is a plus inverted b plus one; carry out set means no borrow.
    assign w_full = {1'b0, i_req.a}
                  + {1'b0, (i_req.b ^ {ALU_W{i_req.sub}})}
                  + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.sum = w_full[ALU_W-1:0];
    assign o_rsp.carry = w_full[ALU_W];

endmodule
`default_nettype wire

@@ design/epoch_bucket_reducer.sv @@
// Epoch bucket reducer.
// Slots enter on the input channel (i_in_valid / o_in_ready) as one struct with
// value, meta, epoch and last. Each transfer is merged into a single accumulator
// for the newest nonzero epoch; the slot flagged last closes the run and yields
// one result transfer on the output channel (o_out_valid / i_out_ready).
// All arithmetic goes through one shared 65-bit add/subtract unit under a small
// sequencer, so the block takes one slot at a time and drops o_in_ready while
// it works. A slot passes through an epoch compare and a wrap-up step; when it
// merges, a merge step lies between them, two for an average merge (value then
// count). A last slot adds a step that loads the output register; before that,
// in average mode with a nonzero epoch and count, a restoring divider on the same
// unit runs, one quotient bit per cycle. The result sits in that register, so
// the next run may start while it waits; a last slot stalls only if the
// previous result has still not been taken. Configuration writes on i_cfg_*
// are always taken and must only be issued while the block is idle.
// Reset (i_rst_n low, synchronous) clears the accumulator, the configuration
// (latest mode, unsigned) and the output valid flag.
`default_nettype none
module epoch_bucket_reducer (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire ebr_pkg::t_ebr_in          i_in,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output ebr_pkg::t_ebr_out              o_out,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [ebr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [ebr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ebr_pkg::*;

    // Sequencer and configuration.
    t_state    r_state, n_state;
    t_agg_mode r_mode;
    logic      r_sign;

    // Captured slot.
    logic [DATA_W-1:0] r_v, r_m, r_e;
    logic              r_last;

    // Accumulator. During a divide, r_acc_value shifts the dividend out at the
    // top and collects the quotient at the bottom.
    logic [DATA_W-1:0] r_best, n_best;
    logic [DATA_W-1:0] r_acc_value, n_acc_value;
    logic [DATA_W-1:0] r_acc_meta, n_acc_meta;

    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    t_ebr_out r_out;
    logic     r_out_valid;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_borrow;
    logic              w_eq;
    logic              w_do_div;
    logic              w_avg_zero;
    logic [DATA_W-1:0] w_sflip;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Signed compares flip the sign bits and then compare unsigned.
    assign w_sflip = {r_sign, {(DATA_W-1){1'b0}}};

    ebr_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_borrow = !w_rsp.carry;
    assign w_eq = (w_rsp.sum[DATA_W-1:0] == '0);
    assign w_avg_zero = (r_mode == MODE_AVG) && (r_acc_meta == '0);
    assign w_do_div = (r_best != '0) && (r_mode == MODE_AVG) && (r_acc_meta != '0);

    // Operand selection for the shared unit.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_EPOCH: begin
                w_req.a = {1'b0, r_best};
                w_req.b = {1'b0, r_e};
                w_req.sub = 1'b1;
            end
            S_MERGE: begin
                case (r_mode) inside
                    MODE_LATEST: begin
                        w_req.a = {1'b0, r_acc_meta};
                        w_req.b = {1'b0, r_m};
                        w_req.sub = 1'b1;
                    end
                    MODE_AVG, MODE_SUM: begin
                        w_req.a = {1'b0, r_acc_value};
                        w_req.b = {1'b0, r_v};
                    end
                    MODE_MAX: begin
                        w_req.a = {1'b0, r_acc_value ^ w_sflip};
                        w_req.b = {1'b0, r_v ^ w_sflip};
                        w_req.sub = 1'b1;
                    end
                    MODE_MIN: begin
                        w_req.a = {1'b0, r_v ^ w_sflip};
                        w_req.b = {1'b0, r_acc_value ^ w_sflip};
                        w_req.sub = 1'b1;
                    end
                    default: begin
                        w_req = '0;
                    end
                endcase
            end
            S_MERGE_META: begin
                w_req.a = {1'b0, r_acc_meta};
                w_req.b = {1'b0, r_m};
            end
            S_DIV: begin
                w_req.a = {r_rem, r_acc_value[DATA_W-1]};
                w_req.b = {1'b0, r_acc_meta};
                w_req.sub = 1'b1;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_EPOCH;
                end
            end
            S_EPOCH: begin
                if ((r_e != '0) && !w_borrow && w_eq) begin
                    n_state = S_MERGE;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_MERGE: begin
                n_state = (r_mode == MODE_AVG) ? S_MERGE_META : S_TAIL;
            end
            S_MERGE_META: begin
                n_state = S_TAIL;
            end
            S_TAIL: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (w_do_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (r_cnt == {DIV_CNT_W{1'b1}}) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Accumulator and divider updates.
    always_comb begin
        n_best = r_best;
        n_acc_value = r_acc_value;
        n_acc_meta = r_acc_meta;
        n_rem = r_rem;
        n_cnt = r_cnt;
        unique case (r_state)
            S_EPOCH: begin
                // A borrow from best minus epoch means a newer epoch.
                if ((r_e != '0) && w_borrow) begin
                    n_best = r_e;
                    n_acc_value = r_v;
                    n_acc_meta = r_m;
                end
            end
            S_MERGE: begin
                case (r_mode) inside
                    MODE_LATEST: begin
                        if (w_borrow) begin
                            n_acc_value = r_v;
                            n_acc_meta = r_m;
                        end
                    end
                    MODE_AVG, MODE_SUM: begin
                        n_acc_value = w_rsp.sum[DATA_W-1:0];
                    end
                    MODE_MAX, MODE_MIN: begin
                        if (w_borrow) begin
                            n_acc_value = r_v;
                        end
                    end
                    default: begin
                        n_acc_value = r_acc_value;
                    end
                endcase
            end
            S_MERGE_META: begin
                n_acc_meta = w_rsp.sum[DATA_W-1:0];
            end
            S_TAIL: begin
                n_rem = '0;
                n_cnt = '0;
            end
            S_DIV: begin
                // Restoring step: keep the difference when it did not borrow.
                if (w_borrow) begin
                    n_rem = {r_rem[DATA_W-2:0], r_acc_value[DATA_W-1]};
                end else begin
                    n_rem = w_rsp.sum[DATA_W-1:0];
                end
                n_acc_value = {r_acc_value[DATA_W-2:0], !w_borrow};
                n_cnt = r_cnt + 1'b1;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_best = '0;
                    n_acc_value = '0;
                    n_acc_meta = '0;
                end
            end
            default: begin
                n_best = r_best;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= MODE_LATEST;
            r_sign <= 1'b0;
            r_best <= '0;
            r_acc_value <= '0;
            r_acc_meta <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_best <= n_best;
            r_acc_value <= n_acc_value;
            r_acc_meta <= n_acc_meta;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_AGG_MODE: r_mode <= t_agg_mode'(i_cfg_data);
                    REG_IS_SIGNED: r_sign <= i_cfg_data[0];
                    default: r_sign <= r_sign;
                endcase
            end
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (w_in_xfer) begin
            r_v <= i_in.slot_value;
            r_m <= i_in.slot_meta;
            r_e <= i_in.slot_epoch;
            r_last <= i_in.last;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out.reduced_value <= ((r_best == '0) || w_avg_zero) ? '0 : r_acc_value;
            r_out.newest_epoch <= r_best;
            r_out.div_zero <= (r_best != '0) && w_avg_zero;
        end
    end

endmodule
`default_nettype wire
